// ----- rtl/vspl_pkg.sv -----
// ----------------------------------------------------------------------------
// Variable-step low-pass filter package
// Shared widths, constants and status structures of the filter datapath.
// ----------------------------------------------------------------------------
package vspl_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int ALPHA_WIDTH     = ALPHA_FRAC_BITS + 1;

    localparam int TC_WIDTH   = 20;
    localparam int MS_WIDTH   = 16;
    localparam int RESTART_MS = 300;
    localparam int US_PER_MS  = 1000;
    localparam int MSR_WIDTH  = $clog2(RESTART_MS + 1);
    localparam int TS_WIDTH   = $clog2(RESTART_MS * US_PER_MS + 1);
    localparam int DEN_WIDTH  = ((TC_WIDTH > TS_WIDTH) ? TC_WIDTH : TS_WIDTH) + 1;
    localparam int REM_WIDTH  = DEN_WIDTH + 1;

    localparam int ITERATIONS = ALPHA_WIDTH;
    localparam int CNT_WIDTH  = $clog2(ITERATIONS);

    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    localparam int ACC_WIDTH  = SAMPLE_WIDTH + 2;
    localparam int PROD_WIDTH = SAMPLE_WIDTH + 3;

    localparam logic [TC_WIDTH-1:0]    TC_RESET  = TC_WIDTH'(50000);
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
    localparam logic [ALPHA_WIDTH:0]   ROUND_HALF =
        {2'b00, 1'b1, {(ALPHA_FRAC_BITS - 1){1'b0}}};

    // APB register map: one 32-bit register per word.
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH = PADDR_WIDTH - 2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TIME_CONSTANT = '0;

    typedef struct packed {
        logic                   done;
        logic [ALPHA_WIDTH-1:0] quot;
    } t_div_status;

    typedef struct packed {
        logic                         done;
        logic signed [PROD_WIDTH-1:0] prod;
    } t_mul_status;

endpackage

// ----- rtl/vspl_div.sv -----
// ----------------------------------------------------------------------------
// Serial smoothing-factor divider
// Restoring divide of Tf * 2^F by Tf + Ts, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vspl_div
    import vspl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TC_WIDTH-1:0] i_tc,
    input  logic [TS_WIDTH-1:0] i_ts,
    output t_div_status         o_status
);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic [REM_WIDTH-1:0]   r_rem;
    logic [DEN_WIDTH-1:0]   r_den;
    logic [ALPHA_WIDTH-1:0] r_quot;

    logic [REM_WIDTH:0]     w_trial;
    logic                   w_ge;
    logic [REM_WIDTH-1:0]   w_keep;

    // Tf never exceeds the divisor Tf + Ts, so Tf itself is a valid start.
    assign w_trial = {1'b0, r_rem} - {2'b00, r_den};
    assign w_ge    = ~w_trial[REM_WIDTH];
    assign w_keep  = w_ge ? w_trial[REM_WIDTH-1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_WIDTH'(ITERATIONS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_WIDTH'(i_tc);
            r_den  <= DEN_WIDTH'(i_tc) + DEN_WIDTH'(i_ts);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {w_keep[REM_WIDTH-2:0], 1'b0};
            r_quot <= {r_quot[ALPHA_WIDTH-2:0], w_ge};
        end
    end

    assign o_status.done = r_done;
    assign o_status.quot = r_quot;

endmodule

// ----- rtl/vspl_mul.sv -----
// ----------------------------------------------------------------------------
// Serial blend multiplier
// Multiplies the sample difference by 1 - alpha, one multiplier bit per cycle,
// and rounds the product to nearest at the alpha fraction point.
// ----------------------------------------------------------------------------
module vspl_mul
    import vspl_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIFF_WIDTH-1:0] i_diff,
    input  logic [ALPHA_WIDTH-1:0]       i_mult,
    output t_mul_status                  o_status
);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_WIDTH-1:0]         r_cnt;
    logic signed [DIFF_WIDTH-1:0] r_diff;
    logic [ALPHA_WIDTH-1:0]       r_mult;
    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic [ALPHA_WIDTH-1:0]       r_low;

    logic signed [ACC_WIDTH-1:0]  w_addend;
    logic signed [ACC_WIDTH-1:0]  w_sum;
    logic [ALPHA_WIDTH:0]         w_round;
    logic [1:0]                   w_carry;

    // LSB-first shift-and-add; the accumulator magnitude never exceeds the difference.
    assign w_addend = r_mult[0] ? {r_diff[DIFF_WIDTH-1], r_diff} : '0;
    assign w_sum    = r_acc + w_addend;

    // Full product is acc * 2^(F+1) + low; add one half and drop F bits.
    assign w_round = {1'b0, r_low} + ROUND_HALF;
    assign w_carry = w_round[ALPHA_WIDTH:ALPHA_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_WIDTH'(ITERATIONS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= i_diff;
            r_mult <= i_mult;
            r_acc  <= '0;
            r_low  <= '0;
        end else if (r_busy) begin
            r_mult <= {1'b0, r_mult[ALPHA_WIDTH-1:1]};
            r_acc  <= {w_sum[ACC_WIDTH-1], w_sum[ACC_WIDTH-1:1]};
            r_low  <= {w_sum[0], r_low[ALPHA_WIDTH-1:1]};
        end
    end

    assign o_status.done = r_done;
    assign o_status.prod = {r_acc, 1'b0} + {{(PROD_WIDTH - 2){1'b0}}, w_carry};

endmodule

// ----- rtl/variable_step_lowpass_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Variable-step low-pass filter unit
// First-order low-pass filter whose smoothing factor follows the elapsed time.
// ----------------------------------------------------------------------------
// Normal path: input transaction, serial divide, serial multiply, then the
// result is released from S_PUT to the output register; a restart sample
// goes from S_IDLE straight to S_PUT.
// A new sample is accepted only in S_IDLE, after the last one is released:
// the serial units run one after the other, and the next sample is taken in S_IDLE.
// Reset: synchronous, active low; time constant 50000 us, stored output zero.
module variable_step_lowpass_filter_unit
    import vspl_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [MS_WIDTH-1:0]            i_elapsed_ms,

    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered,

    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [PADDR_WIDTH-1:0]         paddr,
    input  logic [PDATA_WIDTH-1:0]         pwdata,
    output logic [PDATA_WIDTH-1:0]         prdata,
    output logic                           pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_PUT
    } t_state;

    t_state                         r_state;
    logic [TC_WIDTH-1:0]            r_tc;
    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_filtered;

    logic                           w_in_take;
    logic                           w_restart;
    logic [TS_WIDTH-1:0]            w_ts;
    logic                           w_div_start;
    logic                           w_mul_start;
    t_div_status                    w_div;
    t_mul_status                    w_mul;
    logic [ALPHA_WIDTH-1:0]         w_alpha;
    logic [ALPHA_WIDTH-1:0]         w_mult;
    logic signed [DIFF_WIDTH-1:0]   w_diff;
    logic signed [PROD_WIDTH-1:0]   w_blend;
    logic                           w_out_free;
    logic                           w_release;
    logic                           w_cfg_write;

    // ------------------------------------------------------------------
    // Configuration. The register index is the word address; any write
    // outside the map is dropped, and reads outside the map return zero.
    // ------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= TC_RESET;
        end else if (w_cfg_write &&
                     (paddr[PADDR_WIDTH-1:2] == REG_TIME_CONSTANT)) begin
            r_tc <= pwdata[TC_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_WIDTH-1:2] == REG_TIME_CONSTANT) begin
            prdata = PDATA_WIDTH'(r_tc);
        end
    end

    // ------------------------------------------------------------------
    // Input side. A gap above the restart threshold bypasses the datapath
    // entirely. Otherwise the step Ts in microseconds is formed from the
    // low bits of the elapsed time, which are all that matter at or below
    // the threshold, and the divider starts at once.
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_take   = i_in_valid & o_in_ready;
    assign w_restart   = (i_elapsed_ms > MS_WIDTH'(RESTART_MS));
    assign w_ts        = TS_WIDTH'(i_elapsed_ms[MSR_WIDTH-1:0] * US_PER_MS);
    assign w_div_start = w_in_take & ~w_restart;

    vspl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_tc     (r_tc),
        .i_ts     (w_ts),
        .o_status (w_div)
    );

    // ------------------------------------------------------------------
    // Alpha is Tf * 2^F / (Tf + Ts). It can only exceed one when the
    // divisor is zero (Tf and Ts both zero), where the all-ones quotient
    // clamps to one and the filter simply holds its previous value.
    // The multiplier then works on 1 - alpha and the difference between
    // the new sample and the stored output.
    // ------------------------------------------------------------------
    assign w_alpha     = (w_div.quot > ALPHA_ONE) ? ALPHA_ONE : w_div.quot;
    assign w_mult      = ALPHA_ONE - w_alpha;
    assign w_diff      = {r_sample[SAMPLE_WIDTH-1], r_sample} -
                         {r_prev[SAMPLE_WIDTH-1], r_prev};
    assign w_mul_start = (r_state == S_DIV) & w_div.done;

    vspl_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_diff   (w_diff),
        .i_mult   (w_mult),
        .o_status (w_mul)
    );

    // The blended result always lies between the stored output and the
    // sample, so its low bits are the whole answer.
    assign w_blend = {{(PROD_WIDTH - SAMPLE_WIDTH){r_prev[SAMPLE_WIDTH-1]}}, r_prev} +
                     w_mul.prod;

    // ------------------------------------------------------------------
    // Control. The output register parts the two channels: a finished
    // result waits there while the next sample is accepted and processed,
    // and the sequencer only stalls in S_PUT if a second result arrives
    // before the first transaction has completed. A release in the same
    // cycle as the handshake of the previous result keeps valid high.
    // ------------------------------------------------------------------
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_release  = (r_state == S_PUT) & w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_release) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_sample <= i_sample;
                        r_y      <= i_sample;
                        r_state  <= w_restart ? S_PUT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul.done) begin
                        r_y     <= w_blend[SAMPLE_WIDTH-1:0];
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_prev     <= r_y;
                        r_filtered <= r_y;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A restart sample goes straight to the output stage.
    a_restart_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && w_restart) |=> (r_state == S_PUT))
        else $error("restart sample did not bypass the datapath");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    // The multiplier finishes only while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside the multiply phase");

    // A released result appears on the output and becomes the stored value.
    a_result_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && w_out_free) |=>
            (r_out_valid && (r_filtered == $past(r_y)) && (r_prev == $past(r_y))))
        else $error("result was not released to the output and state");

endmodule
